/* rtl/stt_pkg.sv */
// Shared types, token codes and the keyword table of the source text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

    // Longest identifier prefix kept for keyword matching.
    localparam int KEYWORD_MAX_LEN_DEF = 6;

    // Token text length saturates at the smaller of this and 255.
    localparam int MAX_TOKEN_LEN = 255;
    localparam logic [7:0] LEN_CAP = (MAX_TOKEN_LEN < 255) ? 8'(MAX_TOKEN_LEN) : 8'd255;

    // Most tokens that one source byte can cause.
    localparam int MAX_RES = 3;

    localparam logic [30:0] VAL_MAX  = '1;
    localparam logic [19:0] LINE_MAX = '1;

    // Token kinds.
    localparam logic [2:0] TK_INT    = 3'd0;
    localparam logic [2:0] TK_FLOAT  = 3'd1;
    localparam logic [2:0] TK_STRING = 3'd2;
    localparam logic [2:0] TK_IDENT  = 3'd3;
    localparam logic [2:0] TK_KEYWORD = 3'd4;
    localparam logic [2:0] TK_SYMBOL = 3'd5;
    localparam logic [2:0] TK_END    = 3'd6;

    // Two-character symbol codes.
    localparam logic [2:0] PR_SINGLE    = 3'd0;
    localparam logic [2:0] PR_DOT_STAR  = 3'd1;
    localparam logic [2:0] PR_DOT_SLASH = 3'd2;
    localparam logic [2:0] PR_ARROW     = 3'd3;
    localparam logic [2:0] PR_DOT_DOT   = 3'd4;
    localparam logic [2:0] PR_EQ_EQ     = 3'd5;

    localparam int KW_COUNT = 21;

    // Keyword text, right-justified: the first character sits in the highest used byte.
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        "func", "struct", "let", "mut", "if", "else", "for", "in", "return",
        "true", "false", "Matrix", "Void", "Bool", "Int", "Nat", "Scalar",
        "String", "Result", "Ok", "Err"
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd4, 3'd6, 3'd3, 3'd3, 3'd2, 3'd4, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5,
        3'd6, 3'd4, 3'd4, 3'd3, 3'd3, 3'd6, 3'd6, 3'd6, 3'd2, 3'd3
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  kw;
        logic [7:0]  sym_char;
        logic [2:0]  sym_pair;
        logic [30:0] value;
        logic [7:0]  frac;
        logic        ovf;
        logic [7:0]  len;
        logic [19:0] line;
        logic        last;
    } t_token;

    // Tokens caused by one accepted byte, in order, and how many are valid.
    typedef struct packed {
        logic [1:0]                 cnt;
        t_token [MAX_RES-1:0]       tok;
    } t_lex_res;

    function automatic t_token make_tok(
        input logic [2:0]  kind,
        input logic [4:0]  kw,
        input logic [7:0]  sym_char,
        input logic [2:0]  sym_pair,
        input logic [30:0] value,
        input logic [7:0]  frac,
        input logic        ovf,
        input logic [7:0]  len,
        input logic [19:0] line
    );
        t_token t;
        t.kind     = kind;
        t.kw       = kw;
        t.sym_char = sym_char;
        t.sym_pair = sym_pair;
        t.value    = value;
        t.frac     = frac;
        t.ovf      = ovf;
        t.len      = len;
        t.line     = line;
        t.last     = 1'b0;
        return t;
    endfunction

    // Returns the keyword number (1 up) for the prefix bytes and word length, 0 if none.
    // Byte 0 of pfx holds the first character of the word.
    function automatic logic [4:0] kw_lookup(input logic [47:0] pfx, input logic [7:0] len);
        logic [4:0] code;
        logic       hit;
        int         idx;
        code = 5'd0;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = (len == {5'd0, KW_LEN[k]});
            for (int j = 0; j < 6; j++) begin
                if (j < int'(KW_LEN[k])) begin
                    idx = int'(KW_LEN[k]) - 1 - j;
                    if (pfx[j*8 +: 8] != KW_TEXT[k][idx*8 +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit && code == 5'd0) begin
                code = 5'(k + 1);
            end
        end
        return code;
    endfunction

endpackage

/* rtl/stt_lex.sv */
// Lexer state and the per-byte next-state and token logic of the tokenizer.
`timescale 1ns / 1ps

module stt_lex
    import stt_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic [7:0] i_ch,
    input  logic     i_is_end,
    output t_lex_res o_res
);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_SLASH   = 4'd1;
    localparam logic [3:0] M_COMMENT = 4'd2;
    localparam logic [3:0] M_INT     = 4'd3;
    localparam logic [3:0] M_INTDOT  = 4'd4;
    localparam logic [3:0] M_FRAC    = 4'd5;
    localparam logic [3:0] M_STR     = 4'd6;
    localparam logic [3:0] M_IDENT   = 4'd7;
    localparam logic [3:0] M_SYMP    = 4'd8;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam int PFX_W = KEYWORD_MAX_LEN * 8;

    logic [3:0]       r_mode,  n_mode;
    logic [30:0]      r_acc,   n_acc;
    logic             r_sat,   n_sat;
    logic [7:0]       r_frac,  n_frac;
    logic [7:0]       r_len,   n_len;
    logic [PFX_W-1:0] r_pfx,   n_pfx;
    logic [7:0]       r_pend,  n_pend;
    logic [19:0]      r_line,  n_line;
    logic [19:0]      r_start, n_start;

    t_lex_res res;
    logic     c_digit, c_alpha, c_space;
    logic     do_begin, sp_go;
    logic [7:0] sp_char;
    logic [2:0] sp_pair;
    logic [31:0] acc_dig;
    logic [7:0]  len_inc;
    logic [8:0]  len_add2;
    logic [4:0]  kw_code;

    // Accumulate one decimal digit with saturation: {saturated, value}.
    function automatic logic [31:0] add_digit(
        input logic [30:0] acc,
        input logic        sat,
        input logic [7:0]  c
    );
        logic [34:0] p;
        p = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {27'd0, 8'(c - 8'h30)};
        if (sat) begin
            return {1'b1, acc};
        end else if (p > {4'd0, VAL_MAX}) begin
            return {1'b1, VAL_MAX};
        end
        return {1'b0, p[30:0]};
    endfunction

    assign c_digit = (i_ch >= 8'h30) && (i_ch <= 8'h39);
    assign c_alpha = ((i_ch >= 8'h61) && (i_ch <= 8'h7A)) || ((i_ch >= 8'h41) && (i_ch <= 8'h5A));
    assign c_space = (i_ch == 8'h20) || ((i_ch >= 8'h09) && (i_ch <= 8'h0D));

    assign acc_dig  = add_digit(r_acc, r_sat, i_ch);
    assign len_inc  = (r_len < LEN_CAP) ? r_len + 8'd1 : r_len;
    assign len_add2 = {1'b0, r_len} + 9'd2;
    assign kw_code  = kw_lookup(r_pfx[47:0], r_len);

    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_sat   = r_sat;
        n_frac  = r_frac;
        n_len   = r_len;
        n_pfx   = r_pfx;
        n_pend  = r_pend;
        n_line  = r_line;
        n_start = r_start;
        res      = '0;
        do_begin = 1'b0;
        sp_go    = 1'b0;
        sp_char  = r_pend;
        sp_pair  = PR_SINGLE;

        if (i_is_end) begin
            // Flush whatever token is open, then the end token, then back to reset.
            case (r_mode)
                M_SLASH: begin
                    res.tok[res.cnt] = make_tok(TK_SYMBOL, 5'd0, CH_SLASH, PR_SINGLE, 31'd0,
                                                8'd0, 1'b0, 8'd1, r_start);
                    res.cnt = res.cnt + 2'd1;
                end
                M_INT, M_INTDOT: begin
                    res.tok[res.cnt] = make_tok(TK_INT, 5'd0, 8'd0, PR_SINGLE, r_acc, 8'd0,
                                                r_sat, r_len, r_start);
                    res.cnt = res.cnt + 2'd1;
                    if (r_mode == M_INTDOT) begin
                        res.tok[res.cnt] = make_tok(TK_SYMBOL, 5'd0, CH_DOT, PR_SINGLE, 31'd0,
                                                    8'd0, 1'b0, 8'd1, r_start);
                        res.cnt = res.cnt + 2'd1;
                    end
                end
                M_FRAC: begin
                    res.tok[res.cnt] = make_tok(TK_FLOAT, 5'd0, 8'd0, PR_SINGLE, r_acc, r_frac,
                                                r_sat, r_len, r_start);
                    res.cnt = res.cnt + 2'd1;
                end
                M_STR: begin
                    res.tok[res.cnt] = make_tok(TK_STRING, 5'd0, 8'd0, PR_SINGLE, 31'd0, 8'd0,
                                                1'b0, r_len, r_start);
                    res.cnt = res.cnt + 2'd1;
                end
                M_IDENT: begin
                    res.tok[res.cnt] = make_tok((kw_code != 5'd0) ? TK_KEYWORD : TK_IDENT,
                                                kw_code, 8'd0, PR_SINGLE, 31'd0, 8'd0, 1'b0,
                                                r_len, r_start);
                    res.cnt = res.cnt + 2'd1;
                end
                M_SYMP: begin
                    res.tok[res.cnt] = make_tok(TK_SYMBOL, 5'd0, r_pend, PR_SINGLE, 31'd0,
                                                8'd0, 1'b0, 8'd1, r_start);
                    res.cnt = res.cnt + 2'd1;
                end
                default: begin
                end
            endcase
            res.tok[res.cnt] = make_tok(TK_END, 5'd0, 8'd0, PR_SINGLE, 31'd0, 8'd0, 1'b0,
                                        8'd0, r_line);
            res.cnt = res.cnt + 2'd1;
            n_mode  = M_IDLE;
            n_acc   = '0;
            n_sat   = 1'b0;
            n_frac  = '0;
            n_len   = '0;
            n_pfx   = '0;
            n_pend  = '0;
            n_line  = 20'd1;
            n_start = 20'd1;
        end else begin
            case (r_mode)
                M_SLASH: begin
                    if (i_ch == CH_SLASH) begin
                        n_mode = M_COMMENT;
                    end else begin
                        res.tok[res.cnt] = make_tok(TK_SYMBOL, 5'd0, CH_SLASH, PR_SINGLE, 31'd0,
                                                    8'd0, 1'b0, 8'd1, r_start);
                        res.cnt  = res.cnt + 2'd1;
                        do_begin = 1'b1;
                    end
                end
                M_COMMENT: begin
                    do_begin = (i_ch == CH_LF);
                end
                M_INT: begin
                    if (c_digit) begin
                        n_sat = acc_dig[31];
                        n_acc = acc_dig[30:0];
                        n_len = len_inc;
                    end else if (i_ch == CH_DOT) begin
                        n_mode = M_INTDOT;
                    end else begin
                        res.tok[res.cnt] = make_tok(TK_INT, 5'd0, 8'd0, PR_SINGLE, r_acc, 8'd0,
                                                    r_sat, r_len, r_start);
                        res.cnt  = res.cnt + 2'd1;
                        do_begin = 1'b1;
                    end
                end
                M_INTDOT: begin
                    if (c_digit) begin
                        // The point and the first fraction digit both count as text.
                        n_len  = (len_add2 > {1'b0, LEN_CAP}) ? LEN_CAP : len_add2[7:0];
                        n_sat  = acc_dig[31];
                        n_acc  = acc_dig[30:0];
                        n_frac = 8'd1;
                        n_mode = M_FRAC;
                    end else begin
                        // The point was not a decimal point: the integer ends and the
                        // point opens a symbol that this byte may complete.
                        res.tok[res.cnt] = make_tok(TK_INT, 5'd0, 8'd0, PR_SINGLE, r_acc, 8'd0,
                                                    r_sat, r_len, r_start);
                        res.cnt = res.cnt + 2'd1;
                        sp_go   = 1'b1;
                        sp_char = CH_DOT;
                    end
                end
                M_FRAC: begin
                    if (c_digit) begin
                        n_sat  = acc_dig[31];
                        n_acc  = acc_dig[30:0];
                        n_len  = len_inc;
                        n_frac = (r_frac != 8'hFF) ? r_frac + 8'd1 : r_frac;
                    end else begin
                        res.tok[res.cnt] = make_tok(TK_FLOAT, 5'd0, 8'd0, PR_SINGLE, r_acc,
                                                    r_frac, r_sat, r_len, r_start);
                        res.cnt  = res.cnt + 2'd1;
                        do_begin = 1'b1;
                    end
                end
                M_STR: begin
                    if (i_ch == CH_QUOTE) begin
                        res.tok[res.cnt] = make_tok(TK_STRING, 5'd0, 8'd0, PR_SINGLE, 31'd0,
                                                    8'd0, 1'b0, r_len, r_start);
                        res.cnt = res.cnt + 2'd1;
                        n_mode  = M_IDLE;
                    end else begin
                        n_len = len_inc;
                    end
                end
                M_IDENT: begin
                    if (c_alpha || c_digit || i_ch == CH_UNDER) begin
                        for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                            if (r_len == 8'(j)) begin
                                n_pfx[j*8 +: 8] = i_ch;
                            end
                        end
                        n_len = len_inc;
                    end else begin
                        res.tok[res.cnt] = make_tok((kw_code != 5'd0) ? TK_KEYWORD : TK_IDENT,
                                                    kw_code, 8'd0, PR_SINGLE, 31'd0, 8'd0, 1'b0,
                                                    r_len, r_start);
                        res.cnt  = res.cnt + 2'd1;
                        do_begin = 1'b1;
                    end
                end
                M_SYMP: begin
                    sp_go = 1'b1;
                end
                default: begin
                    do_begin = 1'b1;
                end
            endcase

            // A held symbol character meets the next byte: either a pair or a single.
            if (sp_go) begin
                if (sp_char == CH_DOT && i_ch == CH_STAR) begin
                    sp_pair = PR_DOT_STAR;
                end else if (sp_char == CH_DOT && i_ch == CH_SLASH) begin
                    sp_pair = PR_DOT_SLASH;
                end else if (sp_char == CH_MINUS && i_ch == CH_GT) begin
                    sp_pair = PR_ARROW;
                end else if (sp_char == CH_DOT && i_ch == CH_DOT) begin
                    sp_pair = PR_DOT_DOT;
                end else if (sp_char == CH_EQ && i_ch == CH_EQ) begin
                    sp_pair = PR_EQ_EQ;
                end
                if (sp_pair != PR_SINGLE) begin
                    res.tok[res.cnt] = make_tok(TK_SYMBOL, 5'd0, sp_char, sp_pair, 31'd0, 8'd0,
                                                1'b0, 8'd2, r_start);
                    res.cnt = res.cnt + 2'd1;
                    n_mode  = M_IDLE;
                end else begin
                    res.tok[res.cnt] = make_tok(TK_SYMBOL, 5'd0, sp_char, PR_SINGLE, 31'd0,
                                                8'd0, 1'b0, 8'd1, r_start);
                    res.cnt  = res.cnt + 2'd1;
                    do_begin = 1'b1;
                end
            end

            // The byte starts something new from the between-tokens state.
            if (do_begin) begin
                n_mode = M_IDLE;
                if (i_ch == CH_LF) begin
                    if (r_line < LINE_MAX) begin
                        n_line = r_line + 20'd1;
                    end
                end else if (!c_space) begin
                    n_start = r_line;
                    if (i_ch == CH_SLASH) begin
                        n_mode = M_SLASH;
                    end else if (c_digit) begin
                        n_mode = M_INT;
                        n_acc  = {27'd0, 4'(i_ch - 8'h30)};
                        n_sat  = 1'b0;
                        n_frac = 8'd0;
                        n_len  = 8'd1;
                    end else if (i_ch == CH_QUOTE) begin
                        n_mode = M_STR;
                        n_len  = 8'd0;
                    end else if (c_alpha || i_ch == CH_UNDER) begin
                        n_mode      = M_IDENT;
                        n_len       = 8'd1;
                        n_pfx[7:0]  = i_ch;
                    end else if (i_ch == CH_DOT || i_ch == CH_MINUS || i_ch == CH_EQ) begin
                        n_mode = M_SYMP;
                        n_pend = i_ch;
                    end else begin
                        res.tok[res.cnt] = make_tok(TK_SYMBOL, 5'd0, i_ch, PR_SINGLE, 31'd0,
                                                    8'd0, 1'b0, 8'd1, r_line);
                        res.cnt = res.cnt + 2'd1;
                    end
                end
            end
        end

        if (res.cnt != 2'd0) begin
            res.tok[res.cnt - 2'd1].last = 1'b1;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_acc   <= '0;
            r_sat   <= 1'b0;
            r_frac  <= '0;
            r_len   <= '0;
            r_pfx   <= '0;
            r_pend  <= '0;
            r_line  <= 20'd1;
            r_start <= 20'd1;
        end else if (i_valid) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_sat   <= n_sat;
            r_frac  <= n_frac;
            r_len   <= n_len;
            r_pfx   <= n_pfx;
            r_pend  <= n_pend;
            r_line  <= n_line;
            r_start <= n_start;
        end
    end

endmodule

/* rtl/source_text_tokenizer_core.sv */
// Top level of the source text tokenizer: byte stream in, token stream out.
`timescale 1ns / 1ps

// Source bytes arrive on the slave stream, one per request: tdata[7:0] holds the
// byte and tlast marks the end of the source (the byte is then ignored). Each
// accepted request yields zero to three tokens on the master stream; the last
// token caused by a request carries tlast. tuser holds the token kind.
// Every request is lexed in the cycle it is accepted, and its tokens sit in a
// four-entry output queue from the next cycle on. The block takes one byte per
// cycle as long as at most one token is queued; s_axis_tready depends only on
// the queue fill, not on m_axis_tready. When the receiver stalls, tokens wait
// in the queue and tready drops once two are held; nothing is lost or repeated.
// Synchronous reset (i_rst_n low) empties the queue and returns the lexer to
// line 1 between tokens. An end request returns the lexer to the same state, so
// the next byte starts a new source.

module source_text_tokenizer_core
    import stt_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // is_end

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] keyword_code, [12:5] symbol_char, [15:13] symbol_pair,
    // [46:16] number_value, [54:47] fraction_digits, [55] number_overflow,
    // [63:56] token_length, [83:64] token_line, [87:84] zero
    output logic [87:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
    output logic        m_axis_tlast    // last_of_run
);

    localparam int QDEPTH = 4;

    logic      in_take, out_take;
    t_lex_res  lex_res;
    t_token    head;

    // Output queue, written up to three entries at once and read at the head.
    t_token      r_q [QDEPTH];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  push_n;

    assign s_axis_tready = (r_cnt <= 3'd1);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_take      = m_axis_tvalid && m_axis_tready;

    stt_lex #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_lex (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_take),
        .i_ch     (s_axis_tdata),
        .i_is_end (s_axis_tlast),
        .o_res    (lex_res)
    );

    assign push_n = in_take ? {1'b0, lex_res.cnt} : 3'd0;
    assign n_cnt  = r_cnt + push_n - {2'd0, out_take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + push_n[1:0];
            r_rp  <= r_rp + {1'b0, out_take};
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (3'(k) < push_n) begin
                r_q[r_wp + 2'(k)] <= lex_res.tok[k];
            end
        end
    end

    assign head = r_q[r_rp];

    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {4'd0, head.line, head.len, head.ovf, head.frac, head.value,
                            head.sym_pair, head.sym_char, head.kw};

endmodule

/* tb/tb_source_text_tokenizer_core.sv */
// Self-checking testbench for the source text tokenizer: byte requests in, tokens out.
`timescale 1ns / 1ps

module tb_source_text_tokenizer_core;
    import stt_pkg::*;

    // Control bytes that count as blanks besides the space: tab up to carriage return.
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // Lexer modes of the predictor, one per kind of partly read token.
    typedef enum logic [3:0] {
        LX_IDLE, LX_SLASH, LX_COMMENT, LX_INT, LX_INTDOT, LX_FRAC, LX_STR, LX_IDENT, LX_SYMP
    } t_lex_mode;

    // One source byte request as it waits in the driver queue. A calm request lets
    // neither side idle around it.
    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
        logic       calm;
    } t_src_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    source_text_tokenizer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] ch
        .s_axis_tlast  (s_axis_tlast),   // is_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // keyword_code .. token_line, then zero pad
        .m_axis_tuser  (m_axis_tuser),   // [2:0] token_kind
        .m_axis_tlast  (m_axis_tlast)    // last_of_run
    );

    always #5 i_clk = ~i_clk;

    // Request queue, expected token store and bookkeeping.
    t_src_req pending_reqs [$];
    t_token   expected_tokens [$];
    int       reqs_total;
    int       reqs_accepted = 0;
    int       error_count = 0;
    int       src_gap = 0;
    int       sink_gap = 0;
    logic     calm_phase = 1'b0;
    logic     sink_calm = 1'b0;
    t_src_req next_req;
    t_token   seen_token;
    t_token   wanted_token;

    // Predictor state: a private copy of the lexer.
    t_lex_mode   lx_mode;
    logic [30:0] acc_value;
    logic        acc_sat;
    logic [7:0]  acc_frac;
    logic [7:0]  text_len;
    logic [7:0]  word_head [KEYWORD_MAX_LEN_DEF];
    logic [7:0]  held_sym;
    logic [19:0] cur_line;
    logic [19:0] tok_line;
    int          run_tokens;

    // The keyword table in numbering order; keyword code is the index plus one.
    function automatic string kw_word(input int k);
        case (k)
            0: return "func";    1: return "struct";  2: return "let";     3: return "mut";
            4: return "if";      5: return "else";    6: return "for";     7: return "in";
            8: return "return";  9: return "true";    10: return "false";  11: return "Matrix";
            12: return "Void";   13: return "Bool";   14: return "Int";    15: return "Nat";
            16: return "Scalar"; 17: return "String"; 18: return "Result"; 19: return "Ok";
            default: return "Err";
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task automatic reset_lexer();
        lx_mode   = LX_IDLE;
        acc_value = '0;
        acc_sat   = 1'b0;
        acc_frac  = '0;
        text_len  = '0;
        for (int j = 0; j < KEYWORD_MAX_LEN_DEF; j++) word_head[j] = 8'd0;
        held_sym  = '0;
        cur_line  = 20'd1;
        tok_line  = 20'd1;
    endtask

    task automatic note_token(input logic [2:0] kind, input logic [4:0] kw,
                              input logic [7:0] sc, input logic [2:0] pair,
                              input logic [30:0] val, input logic [7:0] frac,
                              input logic ovf, input logic [7:0] len,
                              input logic [19:0] line);
        t_token t;
        t.kind     = kind;
        t.kw       = kw;
        t.sym_char = sc;
        t.sym_pair = pair;
        t.value    = val;
        t.frac     = frac;
        t.ovf      = ovf;
        t.len      = len;
        t.line     = line;
        t.last     = 1'b0;
        expected_tokens.push_back(t);
        run_tokens++;
    endtask

    task automatic grow_len();
        if (text_len < LEN_CAP) text_len++;
    endtask

    // Decimal accumulate with saturation at the top of the 31-bit range.
    task automatic add_digit(input logic [7:0] c);
        logic [31:0] d;
        d = 32'(c - "0");
        if (!acc_sat) begin
            if ({1'b0, acc_value} > (32'(VAL_MAX) - d) / 32'd10) begin
                acc_value = VAL_MAX;
                acc_sat   = 1'b1;
            end else begin
                acc_value = 31'({1'b0, acc_value} * 32'd10 + d);
            end
        end
    endtask

    task automatic note_number(input logic [2:0] kind);
        note_token(kind, 5'd0, 8'd0, PR_SINGLE, acc_value,
                   (kind == TK_FLOAT) ? acc_frac : 8'd0, acc_sat, text_len, tok_line);
    endtask

    task automatic note_word();
        logic [4:0] code;
        logic       hit;
        string      w;
        code = 5'd0;
        if (text_len <= KEYWORD_MAX_LEN_DEF) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                w   = kw_word(k);
                hit = (w.len() == int'(text_len)) && (code == 5'd0);
                for (int j = 0; j < w.len(); j++) begin
                    if (word_head[j] != w[j]) hit = 1'b0;
                end
                if (hit) code = 5'(k + 1);
            end
        end
        note_token((code != 5'd0) ? TK_KEYWORD : TK_IDENT, code, 8'd0, PR_SINGLE,
                   31'd0, 8'd0, 1'b0, text_len, tok_line);
    endtask

    // A byte seen between tokens: count a line, skip a blank, or open a token.
    task automatic start_token(input logic [7:0] c);
        lx_mode = LX_IDLE;
        if (c == "\n") begin
            if (cur_line < LINE_MAX) cur_line++;
        end else if (!is_blank(c)) begin
            tok_line = cur_line;
            if (c == "/") begin
                lx_mode = LX_SLASH;
            end else if (is_digit(c)) begin
                lx_mode   = LX_INT;
                acc_value = '0;
                acc_sat   = 1'b0;
                acc_frac  = '0;
                text_len  = 8'd1;
                add_digit(c);
            end else if (c == "\"") begin
                lx_mode  = LX_STR;
                text_len = 8'd0;
            end else if (is_alpha(c) || c == "_") begin
                lx_mode      = LX_IDENT;
                text_len     = 8'd1;
                word_head[0] = c;
            end else if (c == "." || c == "-" || c == "=") begin
                lx_mode  = LX_SYMP;
                held_sym = c;
            end else begin
                note_token(TK_SYMBOL, 5'd0, c, PR_SINGLE, 31'd0, 8'd0, 1'b0, 8'd1, tok_line);
            end
        end
    endtask

    // The held symbol character either pairs with this byte or goes out alone.
    task automatic resolve_symbol(input logic [7:0] c);
        logic [2:0] pair;
        pair = PR_SINGLE;
        if (held_sym == "." && c == "*")      pair = PR_DOT_STAR;
        else if (held_sym == "." && c == "/") pair = PR_DOT_SLASH;
        else if (held_sym == "-" && c == ">") pair = PR_ARROW;
        else if (held_sym == "." && c == ".") pair = PR_DOT_DOT;
        else if (held_sym == "=" && c == "=") pair = PR_EQ_EQ;
        if (pair != PR_SINGLE) begin
            note_token(TK_SYMBOL, 5'd0, held_sym, pair, 31'd0, 8'd0, 1'b0, 8'd2, tok_line);
            lx_mode = LX_IDLE;
        end else begin
            note_token(TK_SYMBOL, 5'd0, held_sym, PR_SINGLE, 31'd0, 8'd0, 1'b0, 8'd1,
                       tok_line);
            start_token(c);
        end
    endtask

    task automatic lex_byte(input logic [7:0] c);
        case (lx_mode)
            LX_SLASH: begin
                if (c == "/") begin
                    lx_mode = LX_COMMENT;
                end else begin
                    note_token(TK_SYMBOL, 5'd0, "/", PR_SINGLE, 31'd0, 8'd0, 1'b0, 8'd1,
                               tok_line);
                    start_token(c);
                end
            end
            LX_COMMENT: begin
                if (c == "\n") start_token(c);
            end
            LX_INT: begin
                if (is_digit(c)) begin
                    add_digit(c);
                    grow_len();
                end else if (c == ".") begin
                    lx_mode = LX_INTDOT;
                end else begin
                    note_number(TK_INT);
                    start_token(c);
                end
            end
            LX_INTDOT: begin
                // The point only belongs to the number if a digit follows it.
                if (is_digit(c)) begin
                    grow_len();
                    grow_len();
                    add_digit(c);
                    acc_frac = 8'd1;
                    lx_mode  = LX_FRAC;
                end else begin
                    note_number(TK_INT);
                    held_sym = ".";
                    lx_mode  = LX_SYMP;
                    resolve_symbol(c);
                end
            end
            LX_FRAC: begin
                if (is_digit(c)) begin
                    add_digit(c);
                    grow_len();
                    if (acc_frac < 8'd255) acc_frac++;
                end else begin
                    note_number(TK_FLOAT);
                    start_token(c);
                end
            end
            LX_STR: begin
                // A newline inside a string is plain text and does not advance the line.
                if (c == "\"") begin
                    note_token(TK_STRING, 5'd0, 8'd0, PR_SINGLE, 31'd0, 8'd0, 1'b0, text_len,
                               tok_line);
                    lx_mode = LX_IDLE;
                end else begin
                    grow_len();
                end
            end
            LX_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    if (text_len < KEYWORD_MAX_LEN_DEF) word_head[text_len] = c;
                    grow_len();
                end else begin
                    note_word();
                    start_token(c);
                end
            end
            LX_SYMP: resolve_symbol(c);
            default: start_token(c);
        endcase
    endtask

    // End of source: flush what is half read, add the end token, return to reset.
    task automatic flush_source();
        case (lx_mode)
            LX_SLASH: note_token(TK_SYMBOL, 5'd0, "/", PR_SINGLE, 31'd0, 8'd0, 1'b0, 8'd1,
                                 tok_line);
            LX_INT: note_number(TK_INT);
            LX_INTDOT: begin
                note_number(TK_INT);
                note_token(TK_SYMBOL, 5'd0, ".", PR_SINGLE, 31'd0, 8'd0, 1'b0, 8'd1,
                           tok_line);
            end
            LX_FRAC: note_number(TK_FLOAT);
            LX_STR: note_token(TK_STRING, 5'd0, 8'd0, PR_SINGLE, 31'd0, 8'd0, 1'b0, text_len,
                               tok_line);
            LX_IDENT: note_word();
            LX_SYMP: note_token(TK_SYMBOL, 5'd0, held_sym, PR_SINGLE, 31'd0, 8'd0, 1'b0,
                                8'd1, tok_line);
            default: ;
        endcase
        note_token(TK_END, 5'd0, 8'd0, PR_SINGLE, 31'd0, 8'd0, 1'b0, 8'd0, cur_line);
        reset_lexer();
    endtask

    // Predicts the tokens of one accepted request and marks the last one of the run.
    task automatic predict_tokens(input logic [7:0] c, input logic is_end);
        t_token t;
        run_tokens = 0;
        if (is_end) flush_source();
        else        lex_byte(c);
        if (run_tokens > 0) begin
            t = expected_tokens.pop_back();
            t.last = 1'b1;
            expected_tokens.push_back(t);
        end
    endtask

    // Stimulus helpers that append requests to the driver queue.
    task automatic queue_byte(input logic [7:0] c);
        t_src_req r;
        r.ch     = c;
        r.is_end = 1'b0;
        r.calm   = calm_phase;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_end();
        t_src_req r;
        r.ch     = 8'($urandom_range(0, 255));
        r.is_end = 1'b1;
        r.calm   = calm_phase;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    task automatic queue_digits(input int n);
        repeat (n) queue_byte(8'("0" + $urandom_range(0, 9)));
    endtask

    function automatic logic [7:0] rand_word_char(input logic lead);
        int pick;
        pick = $urandom_range(lead ? 1 : 0, 3);
        case (pick)
            0: return 8'("0" + $urandom_range(0, 9));
            1: return 8'("a" + $urandom_range(0, 25));
            2: return 8'("A" + $urandom_range(0, 25));
            default: return "_";
        endcase
    endfunction

    function automatic logic [7:0] rand_blank();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0) return "\n";
        if (pick == 1) return 8'($urandom_range(CH_TAB, CH_CR));
        return " ";
    endfunction

    // Mostly well-formed tokens with random content, some noise and end markers.
    task automatic queue_random_token();
        int         n;
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0, 1: begin
                queue_text(kw_word($urandom_range(0, KW_COUNT - 1)));
                if ($urandom_range(0, 3) == 0) queue_byte(rand_word_char(1'b0));
            end
            2, 3: begin
                n = $urandom_range(1, 9);
                queue_byte(rand_word_char(1'b1));
                repeat (n - 1) queue_byte(rand_word_char(1'b0));
            end
            4, 5: queue_digits($urandom_range(1, 12));
            6, 7: begin
                queue_digits($urandom_range(1, 5));
                queue_byte(".");
                queue_digits($urandom_range(1, 6));
            end
            8: begin
                // Integer whose point is not followed by a digit.
                queue_digits($urandom_range(1, 3));
                queue_byte(".");
                case ($urandom_range(0, 4))
                    0: queue_byte("*");
                    1: queue_byte("/");
                    2: queue_byte(".");
                    3: queue_byte(";");
                    default: queue_byte("x");
                endcase
            end
            9: begin
                queue_byte("\"");
                n = $urandom_range(0, 8);
                repeat (n) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == "\"") c = "\n";
                    queue_byte(c);
                end
                if ($urandom_range(0, 9) != 0) queue_byte("\"");
            end
            10: begin
                case ($urandom_range(0, 4))
                    0: queue_text(".*");
                    1: queue_text("./");
                    2: queue_text("->");
                    3: queue_text("..");
                    default: queue_text("==");
                endcase
            end
            11: begin
                case ($urandom_range(0, 5))
                    0: queue_byte("-");
                    1: queue_byte("=");
                    2: queue_byte(".");
                    3: queue_byte("/");
                    default: queue_byte(8'($urandom_range(33, 126)));
                endcase
            end
            12: begin
                queue_text("//");
                n = $urandom_range(0, 6);
                repeat (n) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == "\n") c = "/";
                    queue_byte(c);
                end
                queue_byte("\n");
            end
            13: queue_byte(8'($urandom_range(0, 255)));
            14: queue_byte(rand_blank());
            default: begin
                if ($urandom_range(0, 1) == 0) queue_end();
                else                           queue_byte(" ");
            end
        endcase
        if ($urandom_range(0, 1) == 0) queue_byte(rand_blank());
    endtask

    function automatic string fmt_token(input t_token t);
        return $sformatf("kind=%0d kw=%0d sym=%02h pair=%0d val=%0d frac=%0d ovf=%0d len=%0d %s",
                         t.kind, t.kw, t.sym_char, t.sym_pair, t.value, t.frac, t.ovf, t.len,
                         $sformatf("line=%0d last=%0d", t.line, t.last));
    endfunction

    // Driver: one request on the slave side, refilled from the queue once taken.
    // Each accepted request is fed to the predictor at the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap       <= 0;
            reset_lexer();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_tokens(s_axis_tdata, s_axis_tlast);
                reqs_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    src_gap       <= src_gap - 1;
                end else if (pending_reqs.size() != 0) begin
                    next_req = pending_reqs.pop_front();
                    s_axis_tdata  <= next_req.ch;
                    s_axis_tlast  <= next_req.is_end;
                    s_axis_tvalid <= 1'b1;
                    sink_calm     <= next_req.calm;
                    // Now and then the sender pauses after this request.
                    if (!next_req.calm && $urandom_range(0, 9) == 0) begin
                        src_gap <= $urandom_range(1, 15);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: ready most of the time, with random stall bursts outside calm phases.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
        end else if (sink_gap != 0) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= sink_gap - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!sink_calm && $urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 15);
        end
    end

    // Monitor: every accepted token is checked against the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_token.kind     = m_axis_tuser;
            seen_token.kw       = m_axis_tdata[4:0];
            seen_token.sym_char = m_axis_tdata[12:5];
            seen_token.sym_pair = m_axis_tdata[15:13];
            seen_token.value    = m_axis_tdata[46:16];
            seen_token.frac     = m_axis_tdata[54:47];
            seen_token.ovf      = m_axis_tdata[55];
            seen_token.len      = m_axis_tdata[63:56];
            seen_token.line     = m_axis_tdata[83:64];
            seen_token.last     = m_axis_tlast;
            if (expected_tokens.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("%0t: token with none expected: %s", $realtime,
                             fmt_token(seen_token));
                end
            end else begin
                wanted_token = expected_tokens.pop_front();
                if (seen_token !== wanted_token || m_axis_tdata[87:84] !== 4'd0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("%0t: token mismatch, pad=%h", $realtime, m_axis_tdata[87:84]);
                        $display("  expected %s", fmt_token(wanted_token));
                        $display("  actual   %s", fmt_token(seen_token));
                    end
                end
            end
        end
    end

    // Stimulus build, reset, and the end of the run.
    initial begin
        // Directed part: an integer running into ".*", a lone slash, a newline
        // inside a string, the extreme bytes, both arrow and equality pairs, a
        // comment, a float flushed by the end marker, an integer with a dangling
        // point at the end, and an unterminated string at the end.
        queue_text("1.*/x \"\n\"");
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_text("->==//c\n7.5");
        queue_end();
        queue_text("1.");
        queue_end();
        queue_text("\"q");
        queue_end();

        // Every keyword once, then the random part.
        for (int k = 0; k < KW_COUNT; k++) begin
            queue_text(kw_word(k));
            queue_byte(" ");
        end
        while (pending_reqs.size() < 220) queue_random_token();
        queue_end();

        // Calm tail: tokens on two lines, an end, and a short random stretch with
        // no idling at all.
        calm_phase = 1'b1;
        queue_text("x\ny");
        queue_end();
        while (pending_reqs.size() < 262) queue_random_token();
        queue_end();
        reqs_total = pending_reqs.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_accepted < reqs_total) @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
        // Wait on so that a stray extra token would still be caught.
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_tokens.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
